@@ rtl/core/acss_pkg.sv @@
// Shared types and constants for the converter channel scan sequencer.
package acss_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int CH_W         = 4;
    localparam int CNT_W        = 5;
    localparam int RETRY_W      = 8;
    localparam int TICK_W       = 32;
    localparam int SETTLE_W     = 16;
    localparam int WORD_W       = 16;
    localparam int STATUS_W     = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CNT_W-1:0] COUNT_TOP =
        (MAX_CHANNELS < 16) ? CNT_W'(MAX_CHANNELS) : CNT_W'(16);

    localparam logic [CNT_W-1:0]   CHANNEL_COUNT_RST    = CNT_W'(16);
    localparam logic [TICK_W-1:0]  POLL_RETRY_TICKS_RST = TICK_W'(10000);
    localparam logic [RETRY_W-1:0] POLL_RETRY_LIMIT_RST = RETRY_W'(20);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT    = 2'd0,
        CFG_POLL_RETRY_TICKS = 2'd1,
        CFG_POLL_RETRY_LIMIT = 2'd2,
        CFG_UNUSED           = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ACT_WAIT    = 3'd0,
        ACT_MUX     = 3'd1,
        ACT_TRIGGER = 3'd2,
        ACT_RETRY   = 3'd3,
        ACT_RESULT  = 3'd4,
        ACT_TIMEOUT = 3'd5,
        ACT_RESET   = 3'd6
    } action_t;

    typedef struct packed {
        logic [CNT_W-1:0]   channel_count;
        logic [TICK_W-1:0]  poll_retry_ticks;
        logic [RETRY_W-1:0] poll_retry_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [TICK_W-1:0] elapsed_ticks;
        logic [STATUS_W-1:0]      status_byte;
        logic [WORD_W-1:0]        conversion_word;
        logic [SETTLE_W-1:0]      mux_settle_ticks;
        logic                     priority_request;
        logic [CH_W-1:0]          priority_request_channel;
    } item_t;

    typedef struct packed {
        action_t           action;
        logic [CH_W-1:0]   channel;
        logic [WORD_W-1:0] conversion_value;
    } result_t;

endpackage

@@ rtl/core/acss_step.sv @@
// Sequencer state and the per-tick step logic of the channel scan sequencer.
module acss_step (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  acss_pkg::item_t  item,
    input  acss_pkg::cfg_t   cfg,
    output acss_pkg::result_t result
);
    import acss_pkg::*;

    typedef enum logic [1:0] {
        PH_SELECT  = 2'd0,
        PH_TRIGGER = 2'd1,
        PH_POLL    = 2'd2,
        PH_RESET   = 2'd3
    } phase_t;

    phase_t              phase_reg,      phase_next;
    logic [RETRY_W-1:0]  retries_reg,    retries_next;
    logic [TICK_W-1:0]   wait_reg,       wait_next;
    logic                act_v_reg,      act_v_next;
    logic [CH_W-1:0]     act_ch_reg,     act_ch_next;
    logic                pend_v_reg,     pend_v_next;
    logic [CH_W-1:0]     pend_ch_reg,    pend_ch_next;
    logic [CH_W-1:0]     scan_reg,       scan_next;
    logic [CH_W-1:0]     meas_reg,       meas_next;

    logic [TICK_W-1:0]   elapsed;
    logic [CNT_W-1:0]    count_lim;
    logic [CH_W-1:0]     scan_inc;
    action_t             act;
    logic [WORD_W-1:0]   value;

    always_comb
    begin
        elapsed = item.elapsed_ticks[TICK_W-1] ? '0 : TICK_W'(item.elapsed_ticks);

        count_lim = cfg.channel_count;
        if (count_lim == '0)
        begin
            count_lim = CNT_W'(1);
        end
        if (count_lim > COUNT_TOP)
        begin
            count_lim = COUNT_TOP;
        end

        phase_next   = phase_reg;
        retries_next = retries_reg;
        wait_next    = wait_reg;
        act_v_next   = act_v_reg;
        act_ch_next  = act_ch_reg;
        pend_v_next  = pend_v_reg;
        pend_ch_next = pend_ch_reg;
        scan_next    = scan_reg;
        meas_next    = meas_reg;
        act          = ACT_WAIT;
        value        = '0;
        scan_inc     = scan_reg + CH_W'(1);

        if (item.priority_request && (32'(item.priority_request_channel) < MAX_CHANNELS))
        begin
            pend_v_next  = 1'b1;
            pend_ch_next = item.priority_request_channel;
        end

        if ((wait_reg != '0) && (elapsed < wait_reg))
        begin
            wait_next = wait_reg - elapsed;
            act       = ACT_WAIT;
        end
        else
        begin
            wait_next = '0;
            unique case (phase_reg)
                PH_SELECT:
                begin
                    if (act_v_reg)
                    begin
                        meas_next = act_ch_reg;
                    end
                    else if (pend_v_next)
                    begin
                        act_v_next  = 1'b1;
                        act_ch_next = pend_ch_next;
                        pend_v_next = 1'b0;
                        meas_next   = pend_ch_next;
                    end
                    else
                    begin
                        if ({1'b0, scan_reg} >= count_lim)
                        begin
                            scan_next = '0;
                        end
                        meas_next = scan_next;
                    end
                    wait_next  = TICK_W'(item.mux_settle_ticks);
                    phase_next = PH_TRIGGER;
                    act        = ACT_MUX;
                end
                PH_TRIGGER:
                begin
                    retries_next = cfg.poll_retry_limit;
                    phase_next   = PH_POLL;
                    act          = ACT_TRIGGER;
                end
                PH_POLL:
                begin
                    if (item.status_byte == '0)
                    begin
                        if (act_v_reg && (meas_reg == act_ch_reg))
                        begin
                            act_v_next = 1'b0;
                        end
                        else if ({1'b0, scan_inc} >= count_lim)
                        begin
                            scan_next = '0;
                        end
                        else
                        begin
                            scan_next = scan_inc;
                        end
                        phase_next = PH_SELECT;
                        act        = ACT_RESULT;
                        value      = item.conversion_word;
                    end
                    else if (retries_reg != '0)
                    begin
                        retries_next = retries_reg - RETRY_W'(1);
                        wait_next    = cfg.poll_retry_ticks;
                        act          = ACT_RETRY;
                    end
                    else
                    begin
                        phase_next = PH_RESET;
                        act        = ACT_TIMEOUT;
                    end
                end
                PH_RESET:
                begin
                    phase_next = PH_SELECT;
                    act        = ACT_RESET;
                end
                default:
                begin
                    phase_next = PH_SELECT;
                    act        = ACT_RESET;
                end
            endcase
        end

        result.action           = act;
        result.channel          = meas_next;
        result.conversion_value = value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_RESET;
            retries_reg <= '0;
            wait_reg    <= '0;
            act_v_reg   <= 1'b0;
            act_ch_reg  <= '0;
            pend_v_reg  <= 1'b0;
            pend_ch_reg <= '0;
            scan_reg    <= '0;
            meas_reg    <= '0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            retries_reg <= retries_next;
            wait_reg    <= wait_next;
            act_v_reg   <= act_v_next;
            act_ch_reg  <= act_ch_next;
            pend_v_reg  <= pend_v_next;
            pend_ch_reg <= pend_ch_next;
            scan_reg    <= scan_next;
            meas_reg    <= meas_next;
        end
    end

endmodule

@@ rtl/core/adc_channel_scan_sequencer_top.sv @@
// Top level of the converter channel scan sequencer: config, input and result registers.
//
// Each input transaction is one poll tick: elapsed ticks, converter status and data,
// mux settle delay and an optional priority-channel request. Each tick yields exactly
// one result transaction: an action code, the channel concerned and the conversion value.
// Both channels use valid/ready; a transaction moves when valid and ready are both high.
// The tick is held in the input register, stepped through the sequencer logic and loaded
// into the result register.
// Throughput is one tick per cycle while results are taken; the step from input register
// to result register is combinational.
// Configuration writes (cfg_wen, cfg_index, cfg_data) take effect at once; index 0 channel
// count, 1 poll retry wait, 2 poll limit. The user writes only while the block is idle;
// the block does not enforce this. Reset clears both stages, restores the register defaults
// and puts the sequencer in its reset-device phase, so the first step issues a device reset.
// When the receiver stalls the result holds, the input register still fills, and
// in_ready drops until the result is taken.
module adc_channel_scan_sequencer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [acss_pkg::TICK_W-1:0]  elapsed_ticks,
    input  logic [acss_pkg::STATUS_W-1:0]       status_byte,
    input  logic [acss_pkg::WORD_W-1:0]         conversion_word,
    input  logic [acss_pkg::SETTLE_W-1:0]       mux_settle_ticks,
    input  logic                                priority_request,
    input  logic [acss_pkg::CH_W-1:0]           priority_request_channel,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2:0]                          action,
    output logic [acss_pkg::CH_W-1:0]           channel,
    output logic [acss_pkg::WORD_W-1:0]         conversion_value,
    input  logic                                cfg_wen,
    input  logic [acss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [acss_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import acss_pkg::*;

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    in_full_reg;
    result_t out_reg;
    logic    out_valid_reg;
    result_t step_result;
    logic    advance;

    assign advance  = in_full_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_full_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count    <= CHANNEL_COUNT_RST;
            cfg_reg.poll_retry_ticks <= POLL_RETRY_TICKS_RST;
            cfg_reg.poll_retry_limit <= POLL_RETRY_LIMIT_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CHANNEL_COUNT:    cfg_reg.channel_count    <= cfg_data[CNT_W-1:0];
                CFG_POLL_RETRY_TICKS: cfg_reg.poll_retry_ticks <= cfg_data[TICK_W-1:0];
                CFG_POLL_RETRY_LIMIT: cfg_reg.poll_retry_limit <= cfg_data[RETRY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.elapsed_ticks            <= elapsed_ticks;
            item_reg.status_byte              <= status_byte;
            item_reg.conversion_word          <= conversion_word;
            item_reg.mux_settle_ticks         <= mux_settle_ticks;
            item_reg.priority_request         <= priority_request;
            item_reg.priority_request_channel <= priority_request_channel;
        end
    end

    acss_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= step_result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign action           = out_reg.action;
    assign channel          = out_reg.channel;
    assign conversion_value = out_reg.conversion_value;

endmodule

@@ tb/scan_sb_pkg.sv @@
`timescale 1ns / 100ps
// Scoreboard class for the converter channel scan sequencer: tick predictor and result checks.
package scan_sb_pkg;

    import acss_pkg::*;

    typedef enum logic [1:0] {
        SEQ_SELECT  = 2'd0,
        SEQ_TRIGGER = 2'd1,
        SEQ_POLL    = 2'd2,
        SEQ_RESET   = 2'd3
    } seq_phase_t;

    class scan_action_scoreboard;

        logic [CNT_W-1:0]   count_reg;
        logic [TICK_W-1:0]  retry_wait_reg;
        logic [RETRY_W-1:0] retry_limit_reg;

        seq_phase_t         phase;
        logic [RETRY_W-1:0] retries_left;
        logic [TICK_W-1:0]  wait_left;
        logic               active_valid;
        logic [CH_W-1:0]    active_ch;
        logic               queued_valid;
        logic [CH_W-1:0]    queued_ch;
        logic [CH_W-1:0]    scan_next;
        logic [CH_W-1:0]    measuring_ch;

        result_t            pending_actions[$];
        int                 fail_count;

        function new();
            count_reg       = CHANNEL_COUNT_RST;
            retry_wait_reg  = POLL_RETRY_TICKS_RST;
            retry_limit_reg = POLL_RETRY_LIMIT_RST;
            phase           = SEQ_RESET;
            retries_left    = '0;
            wait_left       = '0;
            active_valid    = 1'b0;
            active_ch       = '0;
            queued_valid    = 1'b0;
            queued_ch       = '0;
            scan_next       = '0;
            measuring_ch    = '0;
            fail_count      = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            fail_count++;
        endtask

        function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CHANNEL_COUNT:    count_reg       = data[CNT_W-1:0];
                CFG_POLL_RETRY_TICKS: retry_wait_reg  = data[TICK_W-1:0];
                CFG_POLL_RETRY_LIMIT: retry_limit_reg = data[RETRY_W-1:0];
                default: ;
            endcase
        endfunction

        function int scan_limit();
            int n;
            n = int'(count_reg);
            if (n < 1) n = 1;
            if (n > MAX_CHANNELS) n = MAX_CHANNELS;
            if (n > 16) n = 16;
            return n;
        endfunction

        function result_t step_sequencer(item_t t);
            logic [TICK_W-1:0] elapsed;
            action_t           act;
            result_t           r;
            elapsed = t.elapsed_ticks[TICK_W-1] ? '0 : t.elapsed_ticks;
            if (t.priority_request && int'(t.priority_request_channel) < MAX_CHANNELS)
            begin
                queued_valid = 1'b1;
                queued_ch    = t.priority_request_channel;
            end
            r.conversion_value = '0;
            if (wait_left != 0 && elapsed < wait_left)
            begin
                wait_left = wait_left - elapsed;
                act       = ACT_WAIT;
            end
            else
            begin
                wait_left = '0;
                case (phase)
                    SEQ_SELECT:
                    begin
                        if (active_valid)
                        begin
                            measuring_ch = active_ch;
                        end
                        else if (queued_valid)
                        begin
                            active_valid = 1'b1;
                            active_ch    = queued_ch;
                            queued_valid = 1'b0;
                            measuring_ch = active_ch;
                        end
                        else
                        begin
                            if (int'(scan_next) >= scan_limit()) scan_next = '0;
                            measuring_ch = scan_next;
                        end
                        wait_left = TICK_W'(t.mux_settle_ticks);
                        phase     = SEQ_TRIGGER;
                        act       = ACT_MUX;
                    end
                    SEQ_TRIGGER:
                    begin
                        retries_left = retry_limit_reg;
                        phase        = SEQ_POLL;
                        act          = ACT_TRIGGER;
                    end
                    SEQ_POLL:
                    begin
                        if (t.status_byte == 0)
                        begin
                            if (active_valid && measuring_ch == active_ch)
                            begin
                                active_valid = 1'b0;
                            end
                            else
                            begin
                                scan_next = scan_next + 1'b1;
                                if (int'(scan_next) >= scan_limit()) scan_next = '0;
                            end
                            phase              = SEQ_SELECT;
                            act                = ACT_RESULT;
                            r.conversion_value = t.conversion_word;
                        end
                        else if (retries_left != 0)
                        begin
                            retries_left = retries_left - 1'b1;
                            wait_left    = retry_wait_reg;
                            act          = ACT_RETRY;
                        end
                        else
                        begin
                            phase = SEQ_RESET;
                            act   = ACT_TIMEOUT;
                        end
                    end
                    default:
                    begin
                        phase = SEQ_SELECT;
                        act   = ACT_RESET;
                    end
                endcase
            end
            r.action  = act;
            r.channel = measuring_ch;
            return r;
        endfunction

        function void note_tick(item_t t);
            pending_actions.push_back(step_sequencer(t));
        endfunction

        task check_action(action_t act, logic [CH_W-1:0] ch, logic [WORD_W-1:0] val);
            result_t want;
            if (pending_actions.size() == 0)
            begin
                report($sformatf("unexpected result action %0d channel %0d value %0h",
                                 int'(act), ch, val));
                return;
            end
            want = pending_actions.pop_front();
            if (act !== want.action)
                report($sformatf("action %0d, expected %0d", int'(act), int'(want.action)));
            if (ch !== want.channel)
                report($sformatf("channel %0d, expected %0d", ch, want.channel));
            if (val !== want.conversion_value)
                report($sformatf("conversion value %0h, expected %0h", val,
                                 want.conversion_value));
        endtask

    endclass

endpackage

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Top testbench for the converter channel scan sequencer: stimulus, handshakes and end check.
module tb_top;

    import acss_pkg::*;
    import scan_sb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    item_t                 tick_bus = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [2:0]            action_port;
    logic [CH_W-1:0]       chan_port;
    logic [WORD_W-1:0]     value_port;
    logic                  cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int                    send_gap_pct = 0;
    int                    recv_gap_pct = 0;
    bit                    hold_request = 1'b0;
    int                    hold_left = 0;
    int                    cycle_count = 0;

    scan_action_scoreboard sb;

    adc_channel_scan_sequencer_top dut (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .in_valid                 (in_valid),
        .in_ready                 (in_ready),
        .elapsed_ticks            (tick_bus.elapsed_ticks),
        .status_byte              (tick_bus.status_byte),
        .conversion_word          (tick_bus.conversion_word),
        .mux_settle_ticks         (tick_bus.mux_settle_ticks),
        .priority_request         (tick_bus.priority_request),
        .priority_request_channel (tick_bus.priority_request_channel),
        .out_valid                (out_valid),
        .out_ready                (out_ready),
        .action                   (action_port),
        .channel                  (chan_port),
        .conversion_value         (value_port),
        .cfg_wen                  (cfg_wen),
        .cfg_index                (cfg_index),
        .cfg_data                 (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_tick(tick_bus);
            if (out_valid && out_ready)
                sb.check_action(action_t'(action_port), chan_port, value_port);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    task automatic send_tick(input item_t it);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        tick_bus <= it;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_fields(input logic [31:0] elapsed, input logic [7:0] status,
                               input logic [15:0] word, input logic [15:0] settle,
                               input logic req, input logic [3:0] req_ch);
        item_t it;
        it.elapsed_ticks            = elapsed;
        it.status_byte              = status;
        it.conversion_word          = word;
        it.mux_settle_ticks         = settle;
        it.priority_request         = req;
        it.priority_request_channel = req_ch;
        send_tick(it);
    endtask

    function automatic item_t random_tick(int big_pct);
        item_t it;
        int    roll;
        roll = $urandom_range(99);
        if (roll < 8)
            it.elapsed_ticks = $urandom | 32'h8000_0000;
        else if (roll < 8 + big_pct)
            it.elapsed_ticks = $urandom & 32'h7FFF_FFFF;
        else if (roll < 40 + big_pct)
            it.elapsed_ticks = '0;
        else
            it.elapsed_ticks = $urandom_range(30);
        it.status_byte     = ($urandom_range(99) < 45) ? 8'h00 : 8'($urandom_range(255));
        it.conversion_word = 16'($urandom);
        roll = $urandom_range(99);
        if (roll < 30)
            it.mux_settle_ticks = '0;
        else if (roll < 90)
            it.mux_settle_ticks = 16'($urandom_range(12));
        else
            it.mux_settle_ticks = 16'($urandom);
        it.priority_request         = ($urandom_range(99) < 15);
        it.priority_request_channel = 4'($urandom_range(15));
        return it;
    endfunction

    task automatic wait_quiet();
        @(posedge clk);
        while (sb.pending_actions.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_register(idx, data);
    endtask

    task automatic program_scan(input logic [31:0] cnt, input logic [31:0] wait_ticks,
                                input logic [31:0] limit);
        write_reg(CFG_CHANNEL_COUNT, cnt);
        write_reg(CFG_POLL_RETRY_TICKS, wait_ticks);
        write_reg(CFG_POLL_RETRY_LIMIT, limit);
        cfg_wen <= 1'b0;
    endtask

    task automatic run_phase(input logic [31:0] cnt, input logic [31:0] wait_ticks,
                             input logic [31:0] limit, input int n_ticks, input int big_pct,
                             input bit stall, input bit poke_unused);
        wait_quiet();
        if (poke_unused)
            write_reg(CFG_UNUSED, $urandom);
        program_scan(cnt, wait_ticks, limit);
        if (stall)
            hold_request = 1'b1;
        repeat (n_ticks) send_tick(random_tick(big_pct));
        in_valid <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_gap_pct = 23;
        recv_gap_pct = 62;
        program_scan(32'd3, 32'd2, 32'd1);

        // device reset, priority channel beyond the count, requests while waiting
        send_fields(32'h8000_0000, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 4'd15);
        send_fields(32'd0, 8'h10, 16'h0000, 16'd3, 1'b0, 4'd0);
        send_fields(32'd1, 8'h00, 16'h0000, 16'd0, 1'b1, 4'd2);
        send_fields(32'hFFFF_FFFF, 8'h00, 16'h0000, 16'd0, 1'b1, 4'd5);
        send_fields(32'd2, 8'h00, 16'h0000, 16'd0, 1'b0, 4'd0);
        send_fields(32'd0, 8'h10, 16'h0000, 16'd0, 1'b0, 4'd0);
        send_fields(32'h7FFF_FFFF, 8'h82, 16'h0000, 16'd0, 1'b0, 4'd0);
        send_fields(32'd0, 8'h38, 16'h0000, 16'd0, 1'b0, 4'd0);
        send_fields(32'd0, 8'h00, 16'h0000, 16'd0, 1'b0, 4'd0);
        send_fields(32'd0, 8'h00, 16'h0000, 16'd0, 1'b0, 4'd0);
        send_fields(32'd0, 8'h00, 16'h1234, 16'd0, 1'b0, 4'd0);
        send_fields(32'd0, 8'h00, 16'h0000, 16'd0, 1'b0, 4'd0);
        send_fields(32'd0, 8'h00, 16'h0000, 16'd0, 1'b0, 4'd0);
        send_fields(32'd0, 8'h00, 16'hFFFF, 16'd0, 1'b0, 4'd0);
        send_fields(32'd0, 8'hFF, 16'h0000, 16'd0, 1'b0, 4'd0);
        send_fields(32'd0, 8'h00, 16'h0000, 16'd0, 1'b0, 4'd0);
        send_fields(32'd0, 8'h38, 16'h0000, 16'd0, 1'b0, 4'd0);
        send_fields(32'd5, 8'h00, 16'hA5A5, 16'd0, 1'b0, 4'd0);
        send_fields(32'd0, 8'h00, 16'h0000, 16'd1, 1'b0, 4'd0);
        send_fields(32'd0, 8'h00, 16'h0000, 16'd0, 1'b0, 4'd0);
        send_fields(32'd1, 8'h00, 16'h5A5A, 16'd0, 1'b0, 4'd0);
        send_fields(32'd0, 8'h00, 16'h0000, 16'd0, 1'b0, 4'd0);
        send_fields(32'd0, 8'h00, 16'h0000, 16'd0, 1'b0, 4'd0);
        send_fields(32'd0, 8'h00, 16'h00FF, 16'd0, 1'b0, 4'd0);
        send_fields(32'd0, 8'h01, 16'h0000, 16'd0, 1'b0, 4'd0);
        in_valid <= 1'b0;

        run_phase(32'd16, 32'd0, 32'd3, 190, 5, 1'b0, 1'b0);
        run_phase(32'd0, 32'd1, 32'd0, 190, 5, 1'b0, 1'b0);
        run_phase(32'hFFFF_FFF1, 32'hFFFF_FFFF, 32'd2, 190, 40, 1'b0, 1'b0);

        send_gap_pct = 62;
        recv_gap_pct = 23;
        run_phase(32'd5, 32'd7, 32'd255, 190, 5, 1'b1, 1'b0);
        run_phase(32'd1, 32'd10000, 32'd20, 190, 30, 1'b0, 1'b0);

        send_gap_pct = 0;
        recv_gap_pct = 0;
        run_phase(32'd31, 32'd3, 32'd1, 190, 5, 1'b1, 1'b0);
        run_phase(32'd9, 32'd0, 32'd4, 190, 5, 1'b0, 1'b1);

        wait_quiet();
        repeat (8) @(posedge clk);
        if (sb.pending_actions.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_actions.size()));
        if (sb.fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ adc_channel_scan_sequencer_top.f @@
rtl/core/acss_pkg.sv
rtl/core/acss_step.sv
rtl/core/adc_channel_scan_sequencer_top.sv
tb/scan_sb_pkg.sv
tb/tb_top.sv
